// File: rtl/lpm_pkg.sv
// ----------------------------------------------------------------------------
// lpm_pkg
// Types, command and status codes, and helpers for the IPv4 prefix table.
// ----------------------------------------------------------------------------
package lpm_pkg;

  localparam int unsigned AddrW = 32;
  localparam int unsigned LenW  = 6;

  localparam logic [LenW-1:0] MaxLen = 6'd32;

  // command codes
  localparam logic [1:0] CMD_ADD    = 2'd0;
  localparam logic [1:0] CMD_DEL    = 2'd1;
  localparam logic [1:0] CMD_LOOKUP = 2'd2;

  // status codes
  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_BADLEN = 2'd1;
  localparam logic [1:0] ST_FULL   = 2'd2;

  typedef struct packed {
    logic [1:0]       cmd;
    logic [AddrW-1:0] addr_or_base;
    logic [LenW-1:0]  prefix_len;
  } in_t;

  typedef struct packed {
    logic [1:0]      status;
    logic            found;
    logic [LenW-1:0] match_len;
  } out_t;

  // one table slot
  typedef struct packed {
    logic             valid;
    logic [LenW-1:0]  len;
    logic [AddrW-1:0] base;
  } entry_t;

  // keep the top len bits of an address; len is 0..32
  function automatic logic [AddrW-1:0] top_mask(input logic [LenW-1:0] len);
    logic [LenW-1:0] sh;
    sh = MaxLen - len;
    if (len == '0) begin
      return '0;
    end
    return {AddrW{1'b1}} << sh;
  endfunction

endpackage

// File: rtl/lpm_cmp.sv
// ----------------------------------------------------------------------------
// lpm_cmp
// Shared masked compare: tests one table slot against the current command.
// ----------------------------------------------------------------------------
module lpm_cmp
  import lpm_pkg::*;
(
  input  logic [AddrW-1:0] addr_i,
  input  logic [LenW-1:0]  key_len_i,
  input  logic             lookup_i,
  input  entry_t           entry_i,
  output logic             hit_o
);

  logic [LenW-1:0]  cmp_len;
  logic [AddrW-1:0] masked;
  logic             len_ok;

  // lookup masks with the slot's length, add/delete with the command's
  assign cmp_len = lookup_i ? entry_i.len : key_len_i;
  assign masked  = addr_i & top_mask(cmp_len);
  assign len_ok  = lookup_i || (entry_i.len == key_len_i);
  assign hit_o   = entry_i.valid && len_ok && (masked == entry_i.base);

endmodule

// File: rtl/ipv4_longest_prefix_match.sv
// ----------------------------------------------------------------------------
// ipv4_longest_prefix_match
// Prefix table with add, delete and longest-prefix lookup by a slot scan.
// ----------------------------------------------------------------------------
//  channel   dir  handshake              payload
//  in        in   in_valid_i/in_stall_o   in_data_i  (in_t)
//  out       out  out_valid_o/out_stall_i out_data_o (out_t)
//
//  An add, delete or lookup makes one pass over the slot memory through the
//  shared compare unit, then a commit. A bad length or an unused command
//  skips the scan and goes straight to the response. After reset a clearing
//  pass empties the table; no beat is taken meanwhile. One beat is in work
//  at a time; a finished result waits in the output register while
//  out_stall_i is high.
// ----------------------------------------------------------------------------
module ipv4_longest_prefix_match
  import lpm_pkg::*;
#(
  parameter int unsigned TABLE_ENTRIES = 64
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_stall_o,
  input  in_t  in_data_i,
  output logic out_valid_o,
  input  logic out_stall_i,
  output out_t out_data_o
);

  localparam int unsigned IdxW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam logic [IdxW-1:0] LastIdx = IdxW'(TABLE_ENTRIES - 1);

  localparam logic [2:0] S_CLEAR  = 3'd0;
  localparam logic [2:0] S_IDLE   = 3'd1;
  localparam logic [2:0] S_SCAN   = 3'd2;
  localparam logic [2:0] S_COMMIT = 3'd3;
  localparam logic [2:0] S_RESP   = 3'd4;

  logic [2:0] state_q, state_d;

  entry_t mem [TABLE_ENTRIES];
  entry_t rdata_q;

  logic            mem_we;
  logic [IdxW-1:0] mem_wa;
  entry_t          mem_wd;

  logic [IdxW-1:0] clr_idx_q;
  logic [IdxW-1:0] rd_idx_q;
  logic            issuing_q;
  logic            chk_vld_q;
  logic            chk_last_q;
  logic [IdxW-1:0] chk_idx_q;

  logic             hit_q;
  logic [IdxW-1:0]  hit_idx_q;
  logic             free_q;
  logic [IdxW-1:0]  free_idx_q;
  logic [LenW-1:0]  best_q;

  logic [1:0]       cmd_q;
  logic [AddrW-1:0] addr_q;
  logic [LenW-1:0]  len_q;
  out_t             res_q;

  logic out_valid_q;
  out_t out_q;

  logic in_acc;
  logic immediate;
  logic is_lookup;
  logic hit;
  logic out_free;

  assign in_stall_o  = (state_q != S_IDLE);
  assign in_acc      = in_valid_i && !in_stall_o;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;
  assign out_free    = !out_valid_q || !out_stall_i;
  assign is_lookup   = (cmd_q == CMD_LOOKUP);

  // bad length on add/delete, or an unused command: no scan
  always_comb begin
    immediate = 1'b0;
    case (in_data_i.cmd)
      CMD_ADD, CMD_DEL: immediate = (in_data_i.prefix_len > MaxLen);
      CMD_LOOKUP:       immediate = 1'b0;
      default:          immediate = 1'b1;
    endcase
  end

  lpm_cmp u_cmp (
    .addr_i    (addr_q),
    .key_len_i (len_q),
    .lookup_i  (is_lookup),
    .entry_i   (rdata_q),
    .hit_o     (hit)
  );

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_CLEAR:  if (clr_idx_q == LastIdx) state_d = S_IDLE;
      S_IDLE: begin
        if (in_acc) state_d = immediate ? S_RESP : S_SCAN;
      end
      S_SCAN:   if (chk_vld_q && chk_last_q) state_d = S_COMMIT;
      S_COMMIT: state_d = S_RESP;
      S_RESP:   if (out_free) state_d = S_IDLE;
      default:  state_d = S_IDLE;
    endcase
  end

  // single write port: clearing pass, insert or remove
  always_comb begin
    mem_we = 1'b0;
    mem_wa = clr_idx_q;
    mem_wd = '0;
    if (state_q == S_CLEAR) begin
      mem_we = 1'b1;
    end else if (state_q == S_COMMIT) begin
      if (cmd_q == CMD_ADD && !hit_q && free_q) begin
        mem_we       = 1'b1;
        mem_wa       = free_idx_q;
        mem_wd.valid = 1'b1;
        mem_wd.len   = len_q;
        mem_wd.base  = addr_q & top_mask(len_q);
      end else if (cmd_q == CMD_DEL && hit_q) begin
        mem_we = 1'b1;
        mem_wa = hit_idx_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    rdata_q <= mem[rd_idx_q];
  end

  // control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      clr_idx_q   <= '0;
      rd_idx_q    <= '0;
      issuing_q   <= 1'b0;
      chk_vld_q   <= 1'b0;
      chk_last_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == S_CLEAR) begin
        clr_idx_q <= clr_idx_q + 1'b1;
      end
      if (in_acc) begin
        rd_idx_q  <= '0;
        issuing_q <= !immediate;
      end else if (issuing_q) begin
        if (rd_idx_q == LastIdx) begin
          issuing_q <= 1'b0;
        end else begin
          rd_idx_q <= rd_idx_q + 1'b1;
        end
      end
      chk_vld_q  <= issuing_q;
      chk_last_q <= (rd_idx_q == LastIdx);
      if (state_q == S_RESP && out_free) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // command, scan results and output payload
  always_ff @(posedge clk_i) begin
    chk_idx_q <= rd_idx_q;
    if (in_acc) begin
      cmd_q        <= in_data_i.cmd;
      addr_q       <= in_data_i.addr_or_base;
      len_q        <= in_data_i.prefix_len;
      hit_q        <= 1'b0;
      free_q       <= 1'b0;
      best_q       <= '0;
      res_q        <= '{status:    (in_data_i.cmd == CMD_ADD || in_data_i.cmd == CMD_DEL)
                                   ? ST_BADLEN : ST_OK,
                        found:     1'b0,
                        match_len: '0};
    end
    if (state_q == S_SCAN && chk_vld_q) begin
      if (hit) begin
        hit_q     <= 1'b1;
        hit_idx_q <= chk_idx_q;
        if (rdata_q.len > best_q) best_q <= rdata_q.len;
      end
      if (!rdata_q.valid && !free_q) begin
        free_q     <= 1'b1;
        free_idx_q <= chk_idx_q;
      end
    end
    if (state_q == S_COMMIT) begin
      res_q.status    <= (cmd_q == CMD_ADD && !hit_q && !free_q) ? ST_FULL : ST_OK;
      res_q.found     <= is_lookup && hit_q;
      res_q.match_len <= (is_lookup && hit_q) ? best_q : '0;
    end
    if (state_q == S_RESP && out_free) begin
      out_q <= res_q;
    end
  end

endmodule
